[sv/ffha_pkg.sv]
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

	localparam int REQ_W   = 12;
	localparam int ADDR_W  = 12;
	localparam int GRANT_W = 12;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_REFUSED = 2'd1,
		ST_FREED   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [REQ_W-1:0]   req_size;
		logic [ADDR_W-1:0]  addr;
	} req_t;

	typedef struct packed {
		logic [GRANT_W-1:0] grant_addr;
		status_t            status;
	} rsp_t;

endpackage

[sv/first_fit_heap_allocator.sv]
// First-fit heap allocator: header memory, chain walker, split and coalesce logic.
// A request is taken when start is high and busy is low; its response appears on rsp for
// exactly one cycle with done high, and must be captured then. The header store is one
// synchronous memory with a single read port, and the walker looks at one block header per
// cycle, so the request cost follows the chain: an allocate finishes at the first block
// that fits (by way of S_FIX when it is split), a free of a block goes through S_NXT to
// S_MRG (straight to S_MRG for the last block), and a zero-size allocate or a null free
// strobes done on the next cycle. A new request may be taken in the cycle in which the
// previous response is shown. No clearing pass follows reset.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ffha_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output ffha_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int CW = ((AW > ffha_pkg::REQ_W) ? AW : ffha_pkg::REQ_W) + 2;

	typedef struct packed {
		logic [AW-1:0] size;
		logic          free;
	} hdr_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_FIX  = 5'b00100,
		S_NXT  = 5'b01000,
		S_MRG  = 5'b10000
	} state_t;

	localparam hdr_t RESET_HDR = '{size: AW'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};
	localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);

	hdr_t mem [HEAP_BYTES];
	hdr_t rdata_s1;
	logic rd0_s1;

	state_t         state_q, state_d;
	ffha_pkg::req_t req_q;
	logic [AW-1:0]  off_q, prev_q, cur_size_q;
	hdr_t           prev_hdr_q;
	logic           has_prev_q, done_q, w0_q;
	ffha_pkg::rsp_t rsp_q;

	hdr_t           hdr;
	logic [AW-1:0]  rd_addr, wr_addr;
	hdr_t           wr_data;
	logic           we;
	logic           finish;
	ffha_pkg::rsp_t fin_rsp;

	logic [CW-1:0] off_c, size_c, reqsz_c, nxt_c, payload_c, rest_c, cur_c;
	logic          at_end, fits, split, hit;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
		rd0_s1   <= (rd_addr == '0);
	end

	assign hdr = (rd0_s1 && !w0_q) ? RESET_HDR : rdata_s1;

	assign off_c     = CW'(off_q);
	assign size_c    = CW'(hdr.size);
	assign reqsz_c   = CW'(req_q.req_size);
	assign cur_c     = CW'(cur_size_q);
	assign nxt_c     = off_c + HDR_C + size_c;
	assign payload_c = off_c + HDR_C;
	assign rest_c    = payload_c + reqsz_c;
	assign at_end    = (nxt_c >= HEAP_C);
	assign fits      = hdr.free && (size_c >= reqsz_c);
	assign split     = (size_c > reqsz_c + HDR_C + CW'(1));
	assign hit       = (payload_c == CW'(req_q.addr));

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		wr_addr = off_q;
		wr_data = '{size: cur_size_q, free: 1'b1};
		we      = 1'b0;
		finish  = 1'b0;
		fin_rsp = '{grant_addr: '0, status: ffha_pkg::ST_IGNORED};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.func == ffha_pkg::FN_ALLOC && req.req_size == '0) begin
						finish = 1'b1;
						fin_rsp.status = ffha_pkg::ST_REFUSED;
					end else if (req.func == ffha_pkg::FN_FREE && req.addr == '0) begin
						finish = 1'b1;
						fin_rsp.status = ffha_pkg::ST_IGNORED;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (req_q.func == ffha_pkg::FN_ALLOC) begin
					if (fits) begin
						if (split) begin
							we      = 1'b1;
							wr_addr = rest_c[AW-1:0];
							wr_data = '{size: AW'(size_c - reqsz_c - HDR_C), free: 1'b1};
							state_d = S_FIX;
						end else begin
							we      = 1'b1;
							wr_addr = off_q;
							wr_data = '{size: hdr.size, free: 1'b0};
							finish  = 1'b1;
							fin_rsp = '{grant_addr: payload_c[ffha_pkg::GRANT_W-1:0],
								status: ffha_pkg::ST_GRANTED};
							state_d = S_IDLE;
						end
					end else if (at_end) begin
						finish  = 1'b1;
						fin_rsp.status = ffha_pkg::ST_REFUSED;
						state_d = S_IDLE;
					end else begin
						rd_addr = nxt_c[AW-1:0];
					end
				end else begin
					if (hit) begin
						if (at_end) begin
							state_d = S_MRG;
						end else begin
							rd_addr = nxt_c[AW-1:0];
							state_d = S_NXT;
						end
					end else if (at_end) begin
						finish  = 1'b1;
						fin_rsp.status = ffha_pkg::ST_IGNORED;
						state_d = S_IDLE;
					end else begin
						rd_addr = nxt_c[AW-1:0];
					end
				end
			end
			S_FIX: begin
				we      = 1'b1;
				wr_addr = off_q;
				wr_data = '{size: cur_size_q, free: 1'b0};
				finish  = 1'b1;
				fin_rsp = '{grant_addr: payload_c[ffha_pkg::GRANT_W-1:0],
					status: ffha_pkg::ST_GRANTED};
				state_d = S_IDLE;
			end
			S_NXT: begin
				state_d = S_MRG;
			end
			S_MRG: begin
				we = 1'b1;
				if (has_prev_q && prev_hdr_q.free) begin
					wr_addr = prev_q;
					wr_data = '{size: AW'(CW'(prev_hdr_q.size) + cur_c + HDR_C), free: 1'b1};
				end else begin
					wr_addr = off_q;
					wr_data = '{size: cur_size_q, free: 1'b1};
				end
				finish  = 1'b1;
				fin_rsp.status = ffha_pkg::ST_FREED;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			has_prev_q <= 1'b0;
			done_q     <= 1'b0;
			w0_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (we && wr_addr == '0) begin
				w0_q <= 1'b1;
			end
			if (state_q == S_IDLE) begin
				has_prev_q <= 1'b0;
			end else if (state_q == S_WALK && req_q.func == ffha_pkg::FN_FREE && !hit) begin
				has_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= fin_rsp;
		end
		unique case (state_q)
			S_IDLE: begin
				req_q <= req;
				off_q <= '0;
			end
			S_WALK: begin
				if (req_q.func == ffha_pkg::FN_ALLOC) begin
					if (fits) begin
						cur_size_q <= AW'(reqsz_c);
					end else begin
						off_q <= nxt_c[AW-1:0];
					end
				end else if (hit) begin
					cur_size_q <= hdr.size;
				end else begin
					prev_q     <= off_q;
					prev_hdr_q <= hdr;
					off_q      <= nxt_c[AW-1:0];
				end
			end
			S_NXT: begin
				if (hdr.free) begin
					cur_size_q <= AW'(cur_c + size_c + HDR_C);
				end
			end
			S_FIX, S_MRG: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("response strobe without a request in progress");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_WALK || state_q == S_FIX || state_q == S_MRG))
		else $error("header write outside a modify state");

	a_walk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (off_c < HEAP_C))
		else $error("walker left the heap");

	a_zero_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ffha_pkg::ST_GRANTED) |-> (rsp.grant_addr == '0))
		else $error("nonzero address on a response that grants nothing");

	a_zero_size_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.func == ffha_pkg::FN_ALLOC && req.req_size == '0)
		|=> (done && rsp.status == ffha_pkg::ST_REFUSED))
		else $error("zero-size allocate not refused at once");

endmodule

[bench/ffha_checker.sv]
`timescale 1ns / 1ps
// Checker for the allocator: keeps its own heap image, predicts each response and compares.
module ffha_checker #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  ffha_pkg::req_t   req,
	input  logic             done,
	input  ffha_pkg::rsp_t   rsp,
	output int               errors,
	output int               pending
);

	int unsigned     blk_size [HEAP_BYTES];
	bit              blk_free [HEAP_BYTES];
	ffha_pkg::rsp_t  outcome_q [$];
	ffha_pkg::rsp_t  oldest;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic ffha_pkg::rsp_t allocator_outcome(ffha_pkg::req_t r);
		ffha_pkg::rsp_t o;
		int unsigned    off;
		int unsigned    prev;
		int unsigned    nxt;
		int unsigned    want;
		bit             has_prev;
		bit             found;
		o.grant_addr = '0;
		if (r.func == ffha_pkg::FN_ALLOC) begin
			o.status = ffha_pkg::ST_REFUSED;
			want = r.req_size;
			if (want == 0)
				return o;
			off = 0;
			while (off < HEAP_BYTES) begin
				if (blk_free[off] && blk_size[off] >= want) begin
					if (blk_size[off] > want + HEADER_BYTES + 1) begin
						nxt = off + HEADER_BYTES + want;
						blk_size[nxt] = blk_size[off] - want - HEADER_BYTES;
						blk_free[nxt] = 1'b1;
						blk_size[off] = want;
					end
					blk_free[off] = 1'b0;
					o.grant_addr = ffha_pkg::GRANT_W'(off + HEADER_BYTES);
					o.status = ffha_pkg::ST_GRANTED;
					return o;
				end
				off = off + HEADER_BYTES + blk_size[off];
			end
			return o;
		end
		o.status = ffha_pkg::ST_IGNORED;
		if (r.addr == 0)
			return o;
		off = 0;
		prev = 0;
		has_prev = 1'b0;
		found = 1'b0;
		while (off < HEAP_BYTES && !found) begin
			if (off + HEADER_BYTES == r.addr) begin
				found = 1'b1;
			end else begin
				prev = off;
				has_prev = 1'b1;
				off = off + HEADER_BYTES + blk_size[off];
			end
		end
		if (found) begin
			blk_free[off] = 1'b1;
			nxt = off + HEADER_BYTES + blk_size[off];
			if (nxt < HEAP_BYTES && blk_free[nxt])
				blk_size[off] = blk_size[off] + blk_size[nxt] + HEADER_BYTES;
			if (has_prev && blk_free[prev])
				blk_size[prev] = blk_size[prev] + blk_size[off] + HEADER_BYTES;
			o.status = ffha_pkg::ST_FREED;
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEAP_BYTES; i++) begin
				blk_size[i] = 0;
				blk_free[i] = 1'b0;
			end
			blk_size[0] = HEAP_BYTES - HEADER_BYTES;
			blk_free[0] = 1'b1;
			outcome_q.delete();
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: grant_addr %0d status %0d",
							rsp.grant_addr, rsp.status);
				end else begin
					oldest = outcome_q.pop_front();
					if (rsp.grant_addr !== oldest.grant_addr
						|| rsp.status !== oldest.status) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: expected grant_addr %0d status %0d,",
								" got grant_addr %0d status %0d"},
								oldest.grant_addr, oldest.status,
								rsp.grant_addr, rsp.status);
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(allocator_outcome(req));
		end
		pending = outcome_q.size();
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives allocate and free requests into the allocator and gives the verdict.
module tb;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 400;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	ffha_pkg::req_t  req = '0;
	logic            busy;
	logic            done;
	ffha_pkg::rsp_t  rsp;
	int              errors;
	int              pending;
	int              idle_pct = 0;
	int              phase_idle [4] = '{0, 61, 0, 18};
	logic [11:0]     live [$];
	logic [11:0]     released [$];

	always #5 clk = ~clk;

	first_fit_heap_allocator #(
		.HEAP_BYTES(HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	ffha_checker #(
		.HEAP_BYTES(HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	always @(posedge clk) begin
		if (arst_n && done && rsp.status == ffha_pkg::ST_GRANTED)
			live.push_back(rsp.grant_addr);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: errors");
		$finish;
	end

	task automatic send(ffha_pkg::req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		req = r;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic issue(ffha_pkg::func_t f, int sz, int a);
		ffha_pkg::req_t r;
		r.func = f;
		if (f == ffha_pkg::FN_ALLOC)
			r.req_size = ffha_pkg::REQ_W'(sz);
		else
			r.req_size = ffha_pkg::REQ_W'($urandom_range(4095));
		if (f == ffha_pkg::FN_FREE)
			r.addr = ffha_pkg::ADDR_W'(a);
		else
			r.addr = ffha_pkg::ADDR_W'($urandom_range(4095));
		send(r);
	endtask

	task automatic random_item();
		int          pick;
		int          k;
		int          idx;
		int          sz;
		logic [11:0] a;
		pick = $urandom_range(99);
		if (live.size() > 0 && pick < (live.size() > 24 ? 65 : 40)) begin
			k = $urandom_range(99);
			if (k < 76) begin
				idx = $urandom_range(live.size() - 1);
				a = live[idx];
				live.delete(idx);
				released.push_back(a);
				if (released.size() > 32)
					void'(released.pop_front());
			end else if (k < 84) begin
				a = '0;
			end else if (k < 92 && released.size() > 0) begin
				a = released[$urandom_range(released.size() - 1)];
			end else begin
				a = 12'($urandom_range(4095));
			end
			issue(ffha_pkg::FN_FREE, 0, int'(a));
		end else if (live.size() == 0 && pick < 6) begin
			issue(ffha_pkg::FN_FREE, 0, $urandom_range(4095));
		end else begin
			k = $urandom_range(99);
			if (k < 5)
				sz = 0;
			else if (k < 13)
				sz = $urandom_range(4095);
			else if (k < 25)
				sz = $urandom_range(400, 65);
			else
				sz = $urandom_range(64, 1);
			issue(ffha_pkg::FN_ALLOC, sz, 0);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		issue(ffha_pkg::FN_ALLOC, 0, 0);
		issue(ffha_pkg::FN_ALLOC, 4095, 0);
		issue(ffha_pkg::FN_ALLOC, HEAP_BYTES - HEADER_BYTES + 1, 0);
		issue(ffha_pkg::FN_ALLOC, HEAP_BYTES - HEADER_BYTES, 0);
		issue(ffha_pkg::FN_ALLOC, 1, 0);
		issue(ffha_pkg::FN_FREE, 0, 0);
		issue(ffha_pkg::FN_FREE, 0, 17);
		issue(ffha_pkg::FN_FREE, 0, 4095);
		issue(ffha_pkg::FN_FREE, 0, 16);
		issue(ffha_pkg::FN_ALLOC, HEAP_BYTES - 2 * HEADER_BYTES - 1, 0);
		issue(ffha_pkg::FN_FREE, 0, 16);
		issue(ffha_pkg::FN_ALLOC, HEAP_BYTES - 2 * HEADER_BYTES - 2, 0);
		issue(ffha_pkg::FN_ALLOC, 2, 0);
		issue(ffha_pkg::FN_ALLOC, 3, 0);
		issue(ffha_pkg::FN_FREE, 0, 4094);
		issue(ffha_pkg::FN_FREE, 0, 16);
		issue(ffha_pkg::FN_ALLOC, 100, 0);
		issue(ffha_pkg::FN_ALLOC, 100, 0);
		issue(ffha_pkg::FN_ALLOC, 100, 0);
		issue(ffha_pkg::FN_FREE, 0, 132);
		issue(ffha_pkg::FN_FREE, 0, 16);
		issue(ffha_pkg::FN_FREE, 0, 16);
		issue(ffha_pkg::FN_FREE, 0, 248);
		issue(ffha_pkg::FN_FREE, 0, 248);
		start = 1'b0;
		wait (pending == 0);
		live.delete();
		@(negedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_pct = phase_idle[i / 100];
			random_item();
		end
		start = 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
